@@ sv/prim_minimum_spanning_tree_assert.svh @@
// Assertion macros shared by the spanning tree block.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH

// Plain clocked property, off during reset.
`define PMST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pmst: assertion failed");

// Cause in one cycle, effect in the next.
`define PMST_ASSERT_NEXT(lbl, cause, effect) \
  `PMST_ASSERT(lbl, (cause) |=> (effect))

`endif

@@ sv/pmst_pkg.sv @@
// Shared types, codes and defaults for the spanning tree block.
// No dependencies; used by pmst_ctrl, pmst_datapath and the top level.
package pmst_pkg;

  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_WEIGHT_BITS  = 16;
  localparam logic [5:0] COUNT_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_SOLVE = 2'd3
  } op_t;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_TREE  = 2'd1;
  localparam logic [1:0] KIND_TOTAL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SELF  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {ROW_A, ROW_B, ROW_U} row_sel_t;
  typedef enum logic [1:0] {RW_NONE, RW_ZERO, RW_A, RW_B} row_wr_t;
  typedef enum logic [1:0] {LD_NONE, LD_ACK, LD_TREE, LD_TOTAL} load_t;
  typedef enum logic [1:0] {IX_HOLD, IX_ZERO, IX_ONE, IX_INC} idx_op_t;

  typedef struct packed {
    logic     latch;
    idx_op_t  idx_op;
    row_sel_t row_sel;
    row_wr_t  row_wr;
    logic     w_rd_rlx;
    logic     w_wr_ab;
    logic     w_wr_ba;
    logic     solve_init;
    logic     sel_start;
    logic     sel_issue;
    logic     take;
    logic     rlx_issue;
    load_t    load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic range_bad;
    logic self_loop;
    logic idx_last;
    logic clr_last;
    logic have;
    logic n_gt1;
    logic out_free;
    logic emit_ok;
  } sts_t;

endpackage

@@ sv/pmst_ctrl.sv @@
// Sequencer for the spanning tree block: decodes operations, steps the
// datapath through clear, add, query and Prim passes. Uses pmst_pkg.
module pmst_ctrl import pmst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    CLR, IDLE, DISPATCH, ADD_RD, ADD_WA, ADD_WB, QRY_RD, RESULT,
    S_INIT, SEL, SEL_END, SEL_DONE, RLX, RLX_END, EMIT_RD, EMIT_CHK, TOTAL
  } state_t;

  state_t state, state_next;
  logic   ack_pend, ack_pend_next;

  always_comb begin
    cmd           = '0;
    cmd.idx_op    = IX_HOLD;
    cmd.row_sel   = ROW_A;
    cmd.row_wr    = RW_NONE;
    cmd.load      = LD_NONE;
    cmd.latch     = in_valid && in_ready;
    state_next    = state;
    ack_pend_next = ack_pend;
    case (state)
      CLR: begin
        cmd.row_wr = RW_ZERO;
        if (sts.clr_last) begin
          state_next = ack_pend ? RESULT : IDLE;
        end else begin
          cmd.idx_op = IX_INC;
        end
      end
      IDLE: begin
        if (cmd.latch) state_next = DISPATCH;
      end
      DISPATCH: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.idx_op    = IX_ZERO;
            ack_pend_next = 1'b1;
            state_next    = CLR;
          end
          OP_ADD:   state_next = (sts.range_bad || sts.self_loop) ? RESULT : ADD_RD;
          OP_QUERY: state_next = sts.range_bad ? RESULT : QRY_RD;
          OP_SOLVE: state_next = S_INIT;
          default:  state_next = IDLE;
        endcase
      end
      ADD_RD: state_next = ADD_WA;
      ADD_WA: begin
        cmd.row_sel = ROW_B;
        cmd.row_wr  = RW_A;
        cmd.w_wr_ab = 1'b1;
        state_next  = ADD_WB;
      end
      ADD_WB: begin
        cmd.row_wr  = RW_B;
        cmd.w_wr_ba = 1'b1;
        state_next  = RESULT;
      end
      QRY_RD: state_next = RESULT;
      RESULT: begin
        if (sts.out_free) begin
          cmd.load   = LD_ACK;
          state_next = IDLE;
        end
      end
      S_INIT: begin
        cmd.solve_init = 1'b1;
        cmd.sel_start  = 1'b1;
        cmd.idx_op     = IX_ZERO;
        state_next     = SEL;
      end
      SEL: begin
        cmd.sel_issue = 1'b1;
        if (sts.idx_last) state_next = SEL_END;
        else cmd.idx_op = IX_INC;
      end
      SEL_END: state_next = SEL_DONE;
      SEL_DONE: begin
        if (sts.have) begin
          cmd.take   = 1'b1;
          cmd.idx_op = IX_ZERO;
          state_next = RLX;
        end else if (sts.n_gt1) begin
          cmd.idx_op = IX_ONE;
          state_next = EMIT_RD;
        end else begin
          state_next = TOTAL;
        end
      end
      RLX: begin
        cmd.row_sel   = ROW_U;
        cmd.w_rd_rlx  = 1'b1;
        cmd.rlx_issue = 1'b1;
        if (sts.idx_last) state_next = RLX_END;
        else cmd.idx_op = IX_INC;
      end
      RLX_END: begin
        // last relax update lands here
        cmd.row_sel   = ROW_U;
        cmd.sel_start = 1'b1;
        cmd.idx_op    = IX_ZERO;
        state_next    = SEL;
      end
      EMIT_RD: state_next = EMIT_CHK;
      EMIT_CHK: begin
        if (!sts.emit_ok || sts.out_free) begin
          if (sts.emit_ok) cmd.load = LD_TREE;
          if (sts.idx_last) begin
            state_next = TOTAL;
          end else begin
            cmd.idx_op = IX_INC;
            state_next = EMIT_RD;
          end
        end
      end
      TOTAL: begin
        if (sts.out_free) begin
          cmd.load   = LD_TOTAL;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLR;
      in_ready <= 1'b0;
      ack_pend <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == IDLE);
      ack_pend <= ack_pend_next;
    end
  end

endmodule

@@ sv/pmst_datapath.sv @@
// Datapath of the spanning tree block: adjacency and key memories, scan
// compare, accumulator and output register. Uses pmst_pkg and the assert header.
`include "prim_minimum_spanning_tree_assert.svh"
module pmst_datapath import pmst_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  operation,
  input  logic [4:0]  vertex_a,
  input  logic [4:0]  vertex_b,
  input  logic [15:0] edge_weight,
  input  logic        cfg_valid,
  input  logic [5:0]  cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic        found,
  output logic [4:0]  parent_vertex,
  output logic [4:0]  child_vertex,
  output logic [15:0] tree_edge_weight,
  output logic [20:0] total_weight,
  output logic        last
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int SW = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int XW = (CW > 6) ? CW : 6;

  logic [5:0]    vertex_count;
  op_t           op_r;
  logic [4:0]    a_r, b_r;
  logic [SW-1:0] w_r;

  logic [MAX_VERTICES-1:0] pres_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rowq;
  logic [SW-1:0]           wt_mem [MAX_VERTICES*MAX_VERTICES];
  logic [SW-1:0]           wq;
  logic [SW-1:0]           key_mem [MAX_VERTICES];
  logic [SW-1:0]           keyq;
  logic [VW-1:0]           par_mem [MAX_VERTICES];
  logic [VW-1:0]           parq;

  logic [MAX_VERTICES-1:0] kv, tin, pv;
  logic [VW-1:0] idx, u, cmp_ix, rlx_ix, best_ix;
  logic          cmp_en, rlx_en, have, do_wr;
  logic [SW-1:0] best_key;
  logic [20:0]   total;

  logic [XW-1:0] cnt_x, n_x;
  logic [VW-1:0] a_ix, b_ix, nm1, row_raddr, row_waddr;
  logic [AW-1:0] ab, ba, uv, w_raddr, w_waddr;
  logic [MAX_VERTICES-1:0] row_wdata;
  logic          row_we, wt_we, add_better, sel_cand, rlx_upd, out_free;
  logic          range_bad;
  logic [1:0]    status_code;
  logic          found_bit;

  // active count, clamped to 1..MAX_VERTICES
  always_comb begin
    cnt_x = XW'(vertex_count);
    if (cnt_x == '0) n_x = XW'(1);
    else if (cnt_x > XW'(MAX_VERTICES)) n_x = XW'(MAX_VERTICES);
    else n_x = cnt_x;
  end

  assign nm1       = VW'(n_x - XW'(1));
  assign range_bad = (XW'(a_r) >= n_x) || (XW'(b_r) >= n_x);
  assign a_ix      = VW'(a_r);
  assign b_ix      = VW'(b_r);
  assign ab        = AW'(a_ix) * AW'(MAX_VERTICES) + AW'(b_ix);
  assign ba        = AW'(b_ix) * AW'(MAX_VERTICES) + AW'(a_ix);
  assign uv        = AW'(u) * AW'(MAX_VERTICES) + AW'(idx);
  assign w_raddr   = cmd.w_rd_rlx ? uv : ab;

  always_comb begin
    case (cmd.row_sel)
      ROW_A:   row_raddr = a_ix;
      ROW_B:   row_raddr = b_ix;
      ROW_U:   row_raddr = u;
      default: row_raddr = a_ix;
    endcase
  end

  always_comb begin
    row_we    = 1'b1;
    row_waddr = idx;
    row_wdata = '0;
    case (cmd.row_wr)
      RW_ZERO: row_waddr = idx;
      RW_A: begin
        row_waddr = a_ix;
        row_wdata = rowq | (MAX_VERTICES'(1) << b_ix);
      end
      RW_B: begin
        row_waddr = b_ix;
        row_wdata = rowq | (MAX_VERTICES'(1) << a_ix);
      end
      default: row_we = 1'b0;
    endcase
  end

  // rowq holds row a while the old weight of (a,b) is judged
  assign add_better = !rowq[b_ix] || (w_r < wq);
  assign wt_we      = (cmd.w_wr_ab && add_better) || (cmd.w_wr_ba && do_wr);
  assign w_waddr    = cmd.w_wr_ab ? ab : ba;

  assign sel_cand = cmp_en && !tin[cmp_ix] && kv[cmp_ix] && (!have || keyq < best_key);
  assign rlx_upd  = rlx_en && rowq[rlx_ix] && !tin[rlx_ix] && (!kv[rlx_ix] || wq < keyq);

  always_ff @(posedge clk) begin
    rowq <= pres_mem[row_raddr];
    if (row_we) pres_mem[row_waddr] <= row_wdata;
  end

  always_ff @(posedge clk) begin
    wq <= wt_mem[w_raddr];
    if (wt_we) wt_mem[w_waddr] <= w_r;
  end

  always_ff @(posedge clk) begin
    keyq <= key_mem[idx];
    parq <= par_mem[idx];
    if (cmd.solve_init) key_mem[0] <= '0;
    else if (rlx_upd) key_mem[rlx_ix] <= wq;
    if (rlx_upd) par_mem[rlx_ix] <= u;
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= op_t'(operation);
      a_r  <= vertex_a;
      b_r  <= vertex_b;
      w_r  <= edge_weight[SW-1:0];
    end
    if (cmd.w_wr_ab) do_wr <= add_better;
    cmp_ix <= idx;
    rlx_ix <= idx;
    if (sel_cand) begin
      best_key <= keyq;
      best_ix  <= cmp_ix;
    end
    if (cmd.take) u <= best_ix;
    if (cmd.solve_init) total <= '0;
    else if (cmd.load == LD_TREE) total <= total + 21'(keyq);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_RESET;
      idx          <= '0;
      cmp_en       <= 1'b0;
      rlx_en       <= 1'b0;
      have         <= 1'b0;
      kv           <= '0;
      tin          <= '0;
      pv           <= '0;
    end else begin
      if (cfg_valid) vertex_count <= cfg_data;
      case (cmd.idx_op)
        IX_ZERO: idx <= '0;
        IX_ONE:  idx <= VW'(1);
        IX_INC:  idx <= idx + VW'(1);
        default: idx <= idx;
      endcase
      cmp_en <= cmd.sel_issue;
      rlx_en <= cmd.rlx_issue;
      if (cmd.sel_start) have <= 1'b0;
      else if (sel_cand) have <= 1'b1;
      if (cmd.solve_init) begin
        kv  <= MAX_VERTICES'(1);
        tin <= '0;
        pv  <= '0;
      end else begin
        if (rlx_upd) begin
          kv[rlx_ix] <= 1'b1;
          pv[rlx_ix] <= 1'b1;
        end
        if (cmd.take) tin[best_ix] <= 1'b1;
      end
    end
  end

  // result register; clear always acknowledges with ok
  assign out_free    = !out_valid || out_ready;
  assign status_code = (op_r == OP_CLEAR) ? ST_OK :
                       range_bad ? ST_RANGE :
                       ((op_r == OP_ADD) && (a_r == b_r)) ? ST_SELF : ST_OK;
  assign found_bit   = (op_r == OP_QUERY) && !range_bad && rowq[b_ix];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load != LD_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load != LD_NONE) begin
      kind             <= KIND_ACK;
      status           <= ST_OK;
      found            <= 1'b0;
      parent_vertex    <= '0;
      child_vertex     <= '0;
      tree_edge_weight <= '0;
      total_weight     <= '0;
      last             <= 1'b1;
      case (cmd.load)
        LD_ACK: begin
          status <= status_code;
          found  <= found_bit;
        end
        LD_TREE: begin
          kind             <= KIND_TREE;
          parent_vertex    <= 5'(parq);
          child_vertex     <= 5'(idx);
          tree_edge_weight <= 16'(keyq);
          last             <= 1'b0;
        end
        LD_TOTAL: begin
          kind         <= KIND_TOTAL;
          total_weight <= total;
        end
        default: kind <= KIND_ACK;
      endcase
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.range_bad = range_bad;
    sts.self_loop = (a_r == b_r);
    sts.idx_last  = (idx == nm1);
    sts.clr_last  = (idx == VW'(MAX_VERTICES - 1));
    sts.have      = have;
    sts.n_gt1     = (n_x > XW'(1));
    sts.out_free  = out_free;
    sts.emit_ok   = pv[idx];
  end

  `PMST_ASSERT(a_load_free, (cmd.load != LD_NONE) |-> out_free)
  `PMST_ASSERT(a_no_self_store, (cmd.row_wr == RW_A || cmd.row_wr == RW_B) |-> (a_r != b_r))
  `PMST_ASSERT_NEXT(a_take_marks, cmd.take, tin[$past(best_ix)])

endmodule

@@ sv/prim_minimum_spanning_tree.sv @@
// Prim minimum spanning tree engine over a dense adjacency matrix. Each
// transaction is one operation and is taken only while the engine is idle;
// results leave through a one-entry output register, so a new transaction is
// taken while a result still waits. After reset, and on every clear, the
// engine sweeps the presence rows, one row per cycle, taking no transaction.
// An add does two read-modify-writes of presence rows over one memory port.
// Solve with n active vertices runs one select scan and one relax scan over
// the key and weight memories per reached vertex, then emits the tree edges
// and the total.
// Depends on pmst_pkg, pmst_ctrl and pmst_datapath.
module prim_minimum_spanning_tree import pmst_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [4:0]  vertex_a,
  input  logic [4:0]  vertex_b,
  input  logic [15:0] edge_weight,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic        found,
  output logic [4:0]  parent_vertex,
  output logic [4:0]  child_vertex,
  output logic [15:0] tree_edge_weight,
  output logic [20:0] total_weight,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pmst_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .operation        (operation),
    .vertex_a         (vertex_a),
    .vertex_b         (vertex_b),
    .edge_weight      (edge_weight),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .kind             (kind),
    .status           (status),
    .found            (found),
    .parent_vertex    (parent_vertex),
    .child_vertex     (child_vertex),
    .tree_edge_weight (tree_edge_weight),
    .total_weight     (total_weight),
    .last             (last)
  );

endmodule

@@ tb/prim_minimum_spanning_tree_tb.sv @@
// Self-checking bench for prim_minimum_spanning_tree: directed table, then random graphs.
// Depends on pmst_pkg and the block's RTL; predicts results with its own Prim model.
module prim_minimum_spanning_tree_tb;
  import pmst_pkg::*;

  localparam int NV = 32;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        found;
    logic [4:0]  parent_vertex;
    logic [4:0]  child_vertex;
    logic [15:0] tree_edge_weight;
    logic [20:0] total_weight;
    logic        last;
  } mst_result_t;

  typedef struct {
    op_t         op;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [15:0] w;
    bit          typed;
    mst_result_t res;
  } stim_row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, cfg_valid = 0, out_ready = 0;
  logic in_ready, cfg_ready, out_valid;
  logic [1:0] operation = 0;
  logic [4:0] vertex_a = 0, vertex_b = 0;
  logic [15:0] edge_weight = 0;
  logic [5:0] cfg_data = 0;
  logic [1:0] kind, status;
  logic found, last;
  logic [4:0] parent_vertex, child_vertex;
  logic [15:0] tree_edge_weight;
  logic [20:0] total_weight;

  prim_minimum_spanning_tree dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  logic [5:0]  count_reg;
  logic [15:0] adj_w [NV][NV];
  bit          adj_on [NV][NV];
  mst_result_t expected_q[$];
  int          mismatches = 0;
  int          idle_pct = 15;
  bit          rx_hold = 0;
  int          quiet_cycles = 0;

  function automatic int active_vertices();
    if (count_reg == 0) return 1;
    if (count_reg > NV) return NV;
    return count_reg;
  endfunction

  function automatic mst_result_t mk(logic [1:0] k, logic [1:0] st, logic f,
                                     logic [4:0] p, logic [4:0] c,
                                     logic [15:0] w, logic [20:0] t, logic l);
    mst_result_t r;
    r = '{k, st, f, p, c, w, t, l};
    return r;
  endfunction

  function automatic void queue_result(mst_result_t r);
    expected_q = {expected_q, r};
  endfunction

  task automatic predict_spanning_tree();
    int n, u, v, step;
    bit have;
    logic [15:0] key [NV];
    bit kv [NV], done [NV], pv [NV];
    logic [4:0] par [NV];
    logic [20:0] sum;
    n = active_vertices();
    sum = 0;
    for (int i = 0; i < NV; i++) begin
      kv[i] = 0; done[i] = 0; pv[i] = 0; key[i] = 0; par[i] = 0;
    end
    kv[0] = 1;
    for (step = 0; step < n; step++) begin
      have = 0; u = 0;
      for (int i = 0; i < n; i++)
        if (!done[i] && kv[i] && (!have || key[i] < key[u])) begin
          u = i; have = 1;
        end
      if (!have) break;
      done[u] = 1;
      for (v = 0; v < n; v++)
        if (adj_on[u][v] && !done[v] && (!kv[v] || adj_w[u][v] < key[v])) begin
          key[v] = adj_w[u][v]; kv[v] = 1; par[v] = 5'(u); pv[v] = 1;
        end
    end
    for (int i = 1; i < n; i++)
      if (pv[i]) begin
        queue_result(mk(KIND_TREE, ST_OK, 0, par[i], 5'(i), key[i], 0, 0));
        sum += key[i];
      end
    queue_result(mk(KIND_TOTAL, ST_OK, 0, 0, 0, 0, sum, 1));
  endtask

  task automatic predict_op(op_t op, logic [4:0] a, logic [4:0] b, logic [15:0] w);
    int n;
    n = active_vertices();
    case (op)
      OP_CLEAR: begin
        foreach (adj_on[i, j]) adj_on[i][j] = 0;
        queue_result(mk(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1));
      end
      OP_SOLVE: predict_spanning_tree();
      default: begin
        if (a >= n || b >= n)
          queue_result(mk(KIND_ACK, ST_RANGE, 0, 0, 0, 0, 0, 1));
        else if (op == OP_QUERY)
          queue_result(mk(KIND_ACK, ST_OK, adj_on[a][b], 0, 0, 0, 0, 1));
        else if (a == b)
          queue_result(mk(KIND_ACK, ST_SELF, 0, 0, 0, 0, 0, 1));
        else begin
          if (!adj_on[a][b] || w < adj_w[a][b]) begin
            adj_w[a][b] = w; adj_w[b][a] = w;
          end
          adj_on[a][b] = 1; adj_on[b][a] = 1;
          queue_result(mk(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1));
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, mst_result_t got, mst_result_t exp);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
  endtask

  // result side
  always @(posedge clk) begin
    mst_result_t got, exp;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{kind, status, found, parent_vertex, child_vertex,
                tree_edge_weight, total_weight, last};
        if (expected_q.size() == 0) report_mismatch("unexpected", got, got);
        else begin
          exp = expected_q.pop_front();
          if (got.kind != exp.kind) report_mismatch("kind", got, exp);
          else if (got.status != exp.status) report_mismatch("status", got, exp);
          else if (got.found != exp.found) report_mismatch("found", got, exp);
          else if (got.parent_vertex != exp.parent_vertex) report_mismatch("parent", got, exp);
          else if (got.child_vertex != exp.child_vertex) report_mismatch("child", got, exp);
          else if (got.tree_edge_weight != exp.tree_edge_weight)
            report_mismatch("edge weight", got, exp);
          else if (got.total_weight != exp.total_weight) report_mismatch("total", got, exp);
          else if (got.last != exp.last) report_mismatch("last", got, exp);
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("prim_minimum_spanning_tree_tb failed");
      $finish;
    end
  end

  // valid stays up after an accept until the next transaction or a gap drives it
  task automatic send_op(op_t op, logic [4:0] a, logic [4:0] b, logic [15:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; operation <= op; vertex_a <= a; vertex_b <= b; edge_weight <= w;
    predict_op(op, a, b, w);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [5:0] value);
    drain();
    cfg_valid <= 1; cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    count_reg = value;
  endtask

  task automatic random_graph(int edges);
    int n;
    n = active_vertices();
    send_op(OP_CLEAR, 0, 0, 0);
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(9) == 0)
        send_op(op_t'($urandom_range(2, 1)), 5'($urandom), 5'($urandom), 16'($urandom));
      else
        send_op(OP_ADD, 5'($urandom_range(n - 1)), 5'($urandom_range(n - 1)),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15)));
    end
    send_op(OP_QUERY, 5'($urandom_range(n - 1)), 5'($urandom_range(n - 1)), 0);
    send_op(OP_SOLVE, 0, 0, 0);
  endtask

  stim_row_t table_rows[$];

  initial begin
    int sent;
    count_reg = COUNT_RESET;
    foreach (adj_on[i, j]) begin adj_on[i][j] = 0; adj_w[i][j] = 0; end
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset count of 32
    table_rows = '{
      '{OP_SOLVE, 0, 0, 0, 1, mk(KIND_TOTAL, ST_OK, 0, 0, 0, 0, 0, 1)},
      '{OP_QUERY, 31, 0, 0, 1, mk(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1)},
      '{OP_ADD, 5, 5, 7, 1, mk(KIND_ACK, ST_SELF, 0, 0, 0, 0, 0, 1)},
      '{OP_ADD, 0, 31, 16'hFFFF, 1, mk(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1)},
      '{OP_ADD, 31, 0, 16'hFFFF, 0, '0},
      '{OP_ADD, 0, 31, 3, 0, '0},
      '{OP_ADD, 0, 31, 9, 0, '0},
      '{OP_ADD, 31, 30, 0, 0, '0},
      '{OP_ADD, 0, 1, 16'hFFFF, 0, '0},
      '{OP_QUERY, 31, 0, 0, 1, mk(KIND_ACK, ST_OK, 1, 0, 0, 0, 0, 1)},
      '{OP_QUERY, 7, 7, 0, 1, mk(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1)},
      '{OP_SOLVE, 0, 0, 0, 0, '0},
      '{OP_CLEAR, 0, 0, 0, 1, mk(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1)},
      '{OP_QUERY, 0, 31, 0, 1, mk(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1)}
    };
    foreach (table_rows[i]) begin
      send_op(table_rows[i].op, table_rows[i].a, table_rows[i].b, table_rows[i].w);
      if (table_rows[i].typed && expected_q[$] != table_rows[i].res)
        report_mismatch("table", expected_q[$], table_rows[i].res);
    end

    // count 0 acts as 1, range errors
    write_count(0);
    table_rows = '{
      '{OP_ADD, 0, 1, 1, 1, mk(KIND_ACK, ST_RANGE, 0, 0, 0, 0, 0, 1)},
      '{OP_QUERY, 1, 0, 0, 1, mk(KIND_ACK, ST_RANGE, 0, 0, 0, 0, 0, 1)},
      '{OP_ADD, 0, 0, 1, 1, mk(KIND_ACK, ST_SELF, 0, 0, 0, 0, 0, 1)},
      '{OP_SOLVE, 0, 0, 0, 1, mk(KIND_TOTAL, ST_OK, 0, 0, 0, 0, 0, 1)}
    };
    foreach (table_rows[i]) begin
      send_op(table_rows[i].op, table_rows[i].a, table_rows[i].b, table_rows[i].w);
      if (table_rows[i].typed && expected_q[$] != table_rows[i].res)
        report_mismatch("table", expected_q[$], table_rows[i].res);
    end
    write_count(63);
    send_op(OP_ADD, 31, 2, 5);
    send_op(OP_SOLVE, 0, 0, 0);

    // receiver stalls for a long stretch while sender keeps pushing
    write_count(4);
    rx_hold = 1;
    fork
      begin repeat (300) @(posedge clk); rx_hold = 0; end
      random_graph(6);
    join
    drain();

    // random phase
    sent = 0;
    while (sent < 340) begin
      case ($urandom_range(4))
        0: write_count(6'($urandom_range(2, 1)));
        1: write_count(32);
        default: write_count(6'($urandom_range(8, 2)));
      endcase
      idle_pct = ($urandom_range(3) == 0) ? 0 : 15;
      for (int g = 0; g < 3; g++) begin
        int ne;
        ne = $urandom_range(2 * active_vertices(), 1);
        if (ne > 40) ne = 40;
        random_graph(ne);
        sent += ne + 3;
      end
    end
    idle_pct = 15;
    drain();
    if (mismatches == 0) $display("prim_minimum_spanning_tree_tb passed");
    else $display("prim_minimum_spanning_tree_tb failed");
    $finish;
  end
endmodule
